### rtl/dhtk_pkg.sv
package dhtk_pkg;

    localparam int DEF_MAX_LAYERS         = 64;
    localparam int DEF_MAX_EXPERTS        = 64;
    localparam int DEF_HEAT_FRACTION_BITS = 12;

    localparam logic [15:0] DECAY_RESET   = 16'd62259;
    localparam logic [6:0]  LAYERS_RESET  = 7'd64;
    localparam logic [6:0]  EXPERTS_RESET = 7'd64;

    localparam logic [2:0]  GEN_SAT       = 3'd4;
    localparam logic [2:0]  BOOST_LIMIT   = 3'd3;
    localparam logic [31:0] WORD_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_SCORE = 2'd2,
        KIND_TOPK  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_DECAY   = 2'd0,
        REG_LAYERS  = 2'd1,
        REG_EXPERTS = 2'd2
    } reg_idx_t;

    typedef enum logic {
        RES_SCORE = 1'b0,
        RES_TOPK  = 1'b1
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RATE,
        ST_DECAY,
        ST_ADD,
        ST_SCORE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

### rtl/dhtk_heat_ram.sv
module dhtk_heat_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/decaying_usage_heat_table_top_k.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | kind token_count layer expert hit_count top_count
// out     | output    | out_valid/out_stall| result_kind score ranked_expert last
// cfg     | input     | cfg_write          | cfg_index cfg_data
//
// Tick: every second tick adds a step that squares the decay rate and a
//   decay sweep through the heat RAM (one read per word, then the multiply
//   and write-back stages drain; 32x32 multiply between read and write-back).
// Add and score: a read, then a write-back or an output load.
// Top-k: k passes, each a scan of ne experts (one RAM read per expert) and
//   one output load.
// Reset: a clearing pass writes zero to all DEPTH words, 4096 by default;
//   in_stall is high throughout. Config writes are taken at any time.
// Output stall holds the block only where a result is waiting to load.
module decaying_usage_heat_table_top_k #(
    parameter int MAX_LAYERS         = dhtk_pkg::DEF_MAX_LAYERS,
    parameter int MAX_EXPERTS        = dhtk_pkg::DEF_MAX_EXPERTS,
    parameter int HEAT_FRACTION_BITS = dhtk_pkg::DEF_HEAT_FRACTION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] token_count,
    input  logic [5:0]  layer,
    input  logic [5:0]  expert,
    input  logic [15:0] hit_count,
    input  logic [6:0]  top_count,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [31:0] score,
    output logic [5:0]  ranked_expert,
    output logic        last,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dhtk_pkg::*;

    localparam int DEPTH = MAX_LAYERS * MAX_EXPERTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int EW    = $clog2(MAX_EXPERTS);
    localparam int NW    = EW + 1;

    // saturating x5 start-up boost
    function automatic logic [31:0] boost(input logic [31:0] h, input logic active);
        logic [34:0] v;
        v = {1'b0, h, 2'b00} + {3'b000, h};
        if (!active)
        begin
            return h;
        end
        return (v > {3'b000, WORD_MAX}) ? WORD_MAX : v[31:0];
    endfunction

    state_t state_reg, state_next;

    logic [15:0] decay_reg;
    logic [6:0]  layers_reg, experts_reg;
    logic        parity_reg, parity_next;
    logic [2:0]  gen_reg, gen_next;

    logic [PW-1:0] ptr_reg, ptr_next;
    logic          s1_valid_reg, s1_valid_next;
    logic [AW-1:0] s1_addr_reg, s1_addr_next;
    logic          s2_valid_reg, s2_valid_next;
    logic [AW-1:0] s2_addr_reg, s2_addr_next;
    logic [31:0]   prod_reg, prod_next;
    logic [31:0]   rate_reg, rate_next;

    logic [AW-1:0] addr_reg, addr_next;
    logic [15:0]   hits_reg, hits_next;
    logic          in_range_reg, in_range_next;

    logic [AW-1:0]          base_reg, base_next;
    logic [NW-1:0]          k_reg, k_next;
    logic [NW-1:0]          cnt_reg, cnt_next;
    logic [NW-1:0]          scan_reg, scan_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [EW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [31:0]            best_reg, best_next;
    logic [EW-1:0]          best_idx_reg, best_idx_next;
    logic                   found_reg, found_next;
    logic [MAX_EXPERTS-1:0] taken_reg, taken_next;

    logic        out_valid_reg, out_valid_next;
    logic        res_kind_reg, res_kind_next;
    logic [31:0] score_reg, score_next;
    logic [5:0]  id_reg, id_next;
    logic        last_reg, last_next;

    // RAM ports
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    logic          accept, out_free, boost_on;
    logic          port_range, layer_ok;
    logic [AW-1:0] port_addr, port_base;
    logic [NW-1:0] ne, want;
    logic [63:0]   prod_full;
    logic [63:0]   add_sum;

    dhtk_heat_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign boost_on = (gen_reg <= BOOST_LIMIT);

    // effective register limits
    assign ne = (32'(experts_reg) < MAX_EXPERTS) ? NW'(experts_reg) : NW'(MAX_EXPERTS);
    assign want = (32'(top_count) < 32'(ne)) ? NW'(top_count) : ne;
    assign layer_ok   = (32'(layer) < 32'(layers_reg)) && (32'(layer) < MAX_LAYERS);
    assign port_range = layer_ok && (32'(expert) < 32'(ne));
    assign port_base  = AW'(32'(layer) * MAX_EXPERTS);
    assign port_addr  = AW'(32'(layer) * MAX_EXPERTS + 32'(expert));

    assign prod_full = 64'(ram_rdata) * 64'(rate_reg);
    assign add_sum   = 64'(ram_rdata) + (64'(hits_reg) << HEAT_FRACTION_BITS);

    always_comb
    begin
        state_next     = state_reg;
        parity_next    = parity_reg;
        gen_next       = gen_reg;
        ptr_next       = ptr_reg;
        s1_valid_next  = 1'b0;
        s1_addr_next   = s1_addr_reg;
        s2_valid_next  = 1'b0;
        s2_addr_next   = s2_addr_reg;
        prod_next      = prod_reg;
        rate_next      = rate_reg;
        addr_next      = addr_reg;
        hits_next      = hits_reg;
        in_range_next  = in_range_reg;
        base_next      = base_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        taken_next     = taken_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_kind_next  = res_kind_reg;
        score_next     = score_reg;
        id_next        = id_reg;
        last_next      = last_reg;

        ram_we    = 1'b0;
        ram_waddr = s2_addr_reg;
        ram_wdata = prod_reg;
        ram_re    = 1'b0;
        ram_raddr = port_addr;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[AW-1:0];
                ram_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == PW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                ram_re    = port_range;
                ram_raddr = port_addr;
                if (accept)
                begin
                    addr_next     = port_addr;
                    hits_next     = hit_count;
                    in_range_next = port_range;
                    case (kind_t'(kind))
                        KIND_TICK:
                        begin
                            parity_next = !parity_reg;
                            if (token_count == 16'd1 && gen_reg < GEN_SAT)
                            begin
                                gen_next = gen_reg + 1'b1;
                            end
                            if (parity_reg)
                            begin
                                state_next = ST_RATE;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (port_range && hit_count != '0)
                            begin
                                state_next = ST_ADD;
                            end
                        end
                        KIND_SCORE:
                        begin
                            state_next = ST_SCORE;
                        end
                        KIND_TOPK:
                        begin
                            base_next  = port_base;
                            k_next     = want;
                            cnt_next   = '0;
                            scan_next  = '0;
                            found_next = 1'b0;
                            taken_next = '0;
                            if (layer_ok && want != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RATE:
            begin
                rate_next  = 32'(decay_reg) * 32'(decay_reg);
                ptr_next   = '0;
                state_next = ST_DECAY;
            end

            ST_DECAY:
            begin
                // read, multiply, write back: three words in flight
                if (ptr_reg != PW'(DEPTH))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = ptr_reg[AW-1:0];
                    s1_valid_next = 1'b1;
                    s1_addr_next  = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + 1'b1;
                end
                if (s1_valid_reg)
                begin
                    s2_valid_next = 1'b1;
                    s2_addr_next  = s1_addr_reg;
                    prod_next     = prod_full[63:32];
                end
                ram_we = s2_valid_reg;
                if (ptr_reg == PW'(DEPTH) && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_ADD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                ram_wdata  = (add_sum > 64'(WORD_MAX)) ? WORD_MAX : add_sum[31:0];
                state_next = ST_IDLE;
            end

            ST_SCORE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_kind_next  = RES_SCORE;
                    score_next     = in_range_reg ? boost(ram_rdata, boost_on) : '0;
                    id_next        = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (scan_reg < ne)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = base_reg + AW'(scan_reg[EW-1:0]);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[EW-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                // strict compare in ascending order keeps ties at the lower id
                if (cmp_valid_reg && !taken_reg[cmp_idx_reg]
                    && (!found_reg || ram_rdata > best_reg))
                begin
                    best_next     = ram_rdata;
                    best_idx_next = cmp_idx_reg;
                    found_next    = 1'b1;
                end
                if (scan_reg == ne && !cmp_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    res_kind_next           = RES_TOPK;
                    score_next              = boost(best_reg, boost_on);
                    id_next                 = 6'(best_idx_reg);
                    last_next               = (cnt_reg + 1'b1 == k_reg);
                    taken_next[best_idx_reg] = 1'b1;
                    cnt_next                = cnt_reg + 1'b1;
                    scan_next               = '0;
                    found_next              = 1'b0;
                    state_next = (cnt_reg + 1'b1 == k_reg) ? ST_IDLE : ST_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            decay_reg     <= DECAY_RESET;
            layers_reg    <= LAYERS_RESET;
            experts_reg   <= EXPERTS_RESET;
            parity_reg    <= 1'b0;
            gen_reg       <= '0;
            ptr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            taken_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            parity_reg    <= parity_next;
            gen_reg       <= gen_next;
            ptr_reg       <= ptr_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            taken_reg     <= taken_next;
            if (cfg_write)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_DECAY:   decay_reg   <= cfg_data;
                    REG_LAYERS:  layers_reg  <= cfg_data[6:0];
                    REG_EXPERTS: experts_reg <= cfg_data[6:0];
                    default:     ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s1_addr_next;
        s2_addr_reg  <= s2_addr_next;
        prod_reg     <= prod_next;
        rate_reg     <= rate_next;
        addr_reg     <= addr_next;
        hits_reg     <= hits_next;
        in_range_reg <= in_range_next;
        base_reg     <= base_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_kind_reg <= res_kind_next;
        score_reg    <= score_next;
        id_reg       <= id_next;
        last_reg     <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = res_kind_reg;
    assign score         = score_reg;
    assign ranked_expert = id_reg;
    assign last          = last_reg;

endmodule

### rtl/dhtk_checker.sv
module dhtk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  kind,
    input logic        out_valid,
    input logic        out_stall,
    input logic        result_kind,
    input logic [31:0] score,
    input logic [5:0]  ranked_expert,
    input logic        last
);
    import dhtk_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(score) && $stable(ranked_expert))
        else $error("stalled result changed");

    // score answers are single and carry no id
    a_score_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_SCORE |-> last && ranked_expert == 6'd0)
        else $error("malformed score answer");

    // a tick never produces a result
    a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_TICK && !out_valid |=> !out_valid)
        else $error("result after tick");

    // a score query keeps the input stalled until its answer is loaded
    a_score_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_SCORE |=> in_stall)
        else $error("input taken during score query");

endmodule

bind decaying_usage_heat_table_top_k dhtk_checker u_dhtk_checker (.*);

### tb/decaying_usage_heat_table_top_k_tb.sv
module decaying_usage_heat_table_top_k_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dhtk_pkg::*;

    localparam int NL = DEF_MAX_LAYERS;
    localparam int NE = DEF_MAX_EXPERTS;
    localparam int FRAC = DEF_HEAT_FRACTION_BITS;
    // idle cycles without any accepted item or result before giving up; covers
    // the clear pass, decay sweeps and 64-pass top-k scans
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] tokens;
        logic [5:0]  layer;
        logic [5:0]  expert;
        logic [15:0] hits;
        logic [6:0]  want;
    } item_t;

    typedef struct packed {
        logic        rkind;
        logic [31:0] score;
        logic [5:0]  id;
        logic        last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [15:0] token_count = '0;
    logic [5:0]  layer = '0;
    logic [5:0]  expert = '0;
    logic [15:0] hit_count = '0;
    logic [6:0]  top_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [31:0] score;
    logic [5:0]  ranked_expert;
    logic        last;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always #6 clk = ~clk;

    decaying_usage_heat_table_top_k dut (.*);

    // predictor state
    logic [31:0] heat [NL*NE];
    logic        parity;
    logic [2:0]  gen_ticks;
    logic [15:0] decay_q16;
    logic [6:0]  layers_cfg;
    logic [6:0]  experts_cfg;

    item_t   pending[$];
    result_t expected_results[$];

    int  send_idle_pct = 38;
    int  recv_idle_pct = 78;
    bit  hold_sender = 1'b0;
    int  quiet_cycles = 0;
    int  errors = 0;

    function automatic logic [31:0] boost(logic [31:0] h);
        logic [34:0] v;
        if (gen_ticks > BOOST_LIMIT)
            return h;
        v = h * 35'd5;
        return (v > WORD_MAX) ? WORD_MAX : v[31:0];
    endfunction

    // advance the heat table for one accepted item and queue its results
    task automatic predict_heat(item_t it);
        int nl, ne, k, best, base;
        logic [63:0] taken;
        logic [31:0] rate;
        logic [32:0] sum;
        logic [63:0] prod;
        result_t r;
        nl = (layers_cfg < NL) ? layers_cfg : NL;
        ne = (experts_cfg < NE) ? experts_cfg : NE;
        base = it.layer * NE;
        case (it.kind)
            KIND_TICK:
            begin
                parity = ~parity;
                if (!parity)
                begin
                    rate = decay_q16 * decay_q16;
                    for (int i = 0; i < NL*NE; i++)
                    begin
                        prod = heat[i] * rate;
                        heat[i] = prod[63:32];
                    end
                end
                if (it.tokens == 16'd1 && gen_ticks < GEN_SAT)
                    gen_ticks++;
            end
            KIND_ADD:
            begin
                if (it.layer < nl && it.expert < ne && it.hits != 0)
                begin
                    sum = heat[base + it.expert] + ({16'd0, it.hits} << FRAC);
                    heat[base + it.expert] = sum[32] ? WORD_MAX : sum[31:0];
                end
            end
            KIND_SCORE:
            begin
                r = '{RES_SCORE, 32'd0, 6'd0, 1'b1};
                if (it.layer < nl && it.expert < ne)
                    r.score = boost(heat[base + it.expert]);
                expected_results.push_back(r);
            end
            default:
            begin
                k = (it.want < ne) ? it.want : ne;
                if (it.layer < nl && k != 0)
                begin
                    taken = '0;
                    for (int i = 0; i < k; i++)
                    begin
                        best = -1;
                        for (int e = 0; e < ne; e++)
                            if (!taken[e] && (best < 0 || heat[base+e] > heat[base+best]))
                                best = e;
                        taken[best] = 1'b1;
                        r = '{RES_TOPK, boost(heat[base+best]), best[5:0], i == k-1};
                        expected_results.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // driver: next item goes out once the current one is taken
    always @(posedge clk)
    begin
        logic fire;
        fire = in_valid && !in_stall;
        if (fire)
            predict_heat('{kind_t'(kind), token_count, layer, expert, hit_count, top_count});
        if ((fire || !in_valid) && rst_n)
        begin
            if (pending.size() > 0 && !hold_sender
                && $urandom_range(99, 0) >= send_idle_pct)
            begin
                item_t it;
                it = pending.pop_front();
                in_valid    <= 1'b1;
                kind        <= it.kind;
                token_count <= it.tokens;
                layer       <= it.layer;
                expert      <= it.expert;
                hit_count   <= it.hits;
                top_count   <= it.want;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        result_t exp_r;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result score=%0h ranked_expert=%0d", score, ranked_expert);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result_kind !== exp_r.rkind)
                begin
                    $error("result_kind exp %0d got %0d", exp_r.rkind, result_kind);
                    errors++;
                end
                if (score !== exp_r.score)
                begin
                    $error("score exp %0h got %0h", exp_r.score, score);
                    errors++;
                end
                if (ranked_expert !== exp_r.id)
                begin
                    $error("ranked_expert exp %0d got %0d", exp_r.id, ranked_expert);
                    errors++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last exp %0d got %0d", exp_r.last, last);
                    errors++;
                end
            end
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic item_t rand_item(bit wide);
        item_t it;
        int sel;
        it.tokens = ($urandom_range(3, 0) == 0) ? 16'd1 : 16'($urandom);
        it.layer  = wide ? 6'($urandom) : 6'($urandom_range(3, 0));
        it.expert = wide ? 6'($urandom) : 6'($urandom_range(7, 0));
        it.hits   = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(40, 0));
        // mostly small k, now and then the whole layer
        it.want   = ($urandom_range(19, 0) == 0) ? 7'($urandom_range(127, 0))
                                                  : 7'($urandom_range(6, 0));
        sel = $urandom_range(99, 0);
        it.kind = (sel < 8) ? KIND_TICK : (sel < 60) ? KIND_ADD
                : (sel < 85) ? KIND_SCORE : KIND_TOPK;
        return it;
    endfunction

    // sampled on the falling edge so every update of the rising edge is seen;
    // in_stall covers a decay sweep still running after the last result
    task automatic wait_drained();
        while (pending.size() > 0 || in_valid || expected_results.size() > 0 || in_stall)
            @(negedge clk);
    endtask

    task automatic set_reg(reg_idx_t idx, int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_DECAY:   decay_q16   = 16'(val);
            REG_LAYERS:  layers_cfg  = 7'(val);
            default:     experts_cfg = 7'(val);
        endcase
    endtask

    task automatic push(kind_t k, int tok, int l, int e, int h, int w);
        pending.push_back('{k, 16'(tok), 6'(l), 6'(e), 16'(h), 7'(w)});
    endtask

    initial
    begin
        for (int i = 0; i < NL*NE; i++)
            heat[i] = '0;
        parity      = 1'b0;
        gen_ticks   = '0;
        decay_q16   = DECAY_RESET;
        layers_cfg  = LAYERS_RESET;
        experts_cfg = EXPERTS_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ties, boost, range limits, both tick paths
        push(KIND_ADD, 0, 0, 0, 16'hFFFF, 0);
        push(KIND_ADD, 0, 0, 0, 16'hFFFF, 0);
        push(KIND_ADD, 0, 0, 1, 16'd0, 0);
        push(KIND_ADD, 0, 63, 63, 16'd7, 0);
        push(KIND_ADD, 0, 0, 2, 16'd3, 0);
        push(KIND_ADD, 0, 0, 3, 16'd3, 0);
        push(KIND_SCORE, 0, 0, 0, 0, 0);
        push(KIND_SCORE, 0, 63, 63, 0, 0);
        push(KIND_TOPK, 0, 0, 0, 0, 7'd5);
        push(KIND_TOPK, 0, 0, 0, 0, 7'd0);
        push(KIND_TOPK, 0, 63, 0, 0, 7'd127);
        push(KIND_TICK, 16'd1, 0, 0, 0, 0);
        push(KIND_TICK, 16'hFFFF, 0, 0, 0, 0);
        push(KIND_SCORE, 0, 0, 2, 0, 0);
        for (int i = 0; i < 4; i++)
            push(KIND_TICK, 16'd1, 0, 0, 0, 0);
        push(KIND_SCORE, 0, 0, 0, 0, 0);
        push(KIND_SCORE, 0, 0, 3, 0, 0);
        wait_drained();

        // narrow layers/experts, extreme decay
        set_reg(REG_DECAY, 16'd0);
        set_reg(REG_LAYERS, 7'd1);
        set_reg(REG_EXPERTS, 7'd1);
        push(KIND_ADD, 0, 1, 0, 16'd9, 0);
        push(KIND_ADD, 0, 0, 1, 16'd9, 0);
        push(KIND_SCORE, 0, 1, 0, 0, 0);
        push(KIND_TOPK, 0, 0, 0, 0, 7'd64);
        push(KIND_TICK, 0, 0, 0, 0, 0);
        push(KIND_TICK, 0, 0, 0, 0, 0);
        push(KIND_SCORE, 0, 0, 0, 0, 0);
        wait_drained();

        set_reg(REG_DECAY, 16'hFFFF);
        set_reg(REG_LAYERS, 7'd4);
        set_reg(REG_EXPERTS, 7'd8);
        send_idle_pct = 38;
        recv_idle_pct = 78;
        for (int i = 0; i < 90; i++)
            pending.push_back(rand_item(0));
        wait_drained();

        // hold the sender while answers are still outstanding
        for (int i = 0; i < 5; i++)
            pending.push_back(rand_item(0));
        push(KIND_TOPK, 0, 0, 0, 0, 7'd8);
        while (pending.size() > 0)
            @(negedge clk);
        hold_sender = 1'b1;
        for (int i = 0; i < 5; i++)
            pending.push_back(rand_item(0));
        while (in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        hold_sender = 1'b0;
        wait_drained();

        set_reg(REG_DECAY, 16'($urandom));
        set_reg(REG_LAYERS, 7'd127);
        set_reg(REG_EXPERTS, 7'd64);
        send_idle_pct = 78;
        recv_idle_pct = 38;
        for (int i = 0; i < 80; i++)
            pending.push_back(rand_item($urandom_range(3, 0) == 0));
        wait_drained();

        set_reg(REG_DECAY, DECAY_RESET);
        set_reg(REG_EXPERTS, 7'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 10; i++)
            pending.push_back(rand_item(0));
        wait_drained();
        set_reg(REG_EXPERTS, 7'd12);
        for (int i = 0; i < 50; i++)
            pending.push_back(rand_item(0));
        wait_drained();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
